FILE: hdl/tes3_pkg.sv
// ----------------------------------------------------------------------------
// tes3_pkg
// Shared types, constants and helpers for the SE(3) twist exponential.
// ----------------------------------------------------------------------------
package tes3_pkg;

    // Angle constants in Q3.13, held at the width of the reduced angle
    localparam int                  ANG_W       = 18;
    localparam logic signed [17:0]  ANG_PI      = 18'sd25736;
    localparam logic signed [17:0]  ANG_TWO_PI  = 18'sd51472;
    localparam logic signed [17:0]  ANG_HALF_PI = 18'sd12868;

    // CORDIC datapath in Q2.30
    localparam int                  CW          = 34;
    localparam logic signed [33:0]  CORDIC_GAIN = 34'sh026DD3B6A;
    localparam int                  ATAN_ENTRIES = 24;

    // Unit value in Q2.14
    localparam logic signed [15:0]  UNIT_Q14    = 16'sd16384;

    // Wide accumulator for the matrix sums
    localparam int                  AW          = 58;

    // Register indexes of the configuration port
    localparam logic [2:0] REG_AXIS_X   = 3'd0;
    localparam logic [2:0] REG_AXIS_Y   = 3'd1;
    localparam logic [2:0] REG_AXIS_Z   = 3'd2;
    localparam logic [2:0] REG_LINEAR_X = 3'd3;
    localparam logic [2:0] REG_LINEAR_Y = 3'd4;
    localparam logic [2:0] REG_LINEAR_Z = 3'd5;

    // Payload of one CORDIC stage
    typedef struct packed {
        logic               flip;
        logic signed [15:0] th;
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
    } cordic_t;

    // Quantities derived from the twist registers
    typedef struct packed {
        logic                  zero;
        logic [2:0][15:0]      w;
        logic [2:0][15:0]      v;
        logic [2:0][2:0][33:0] w2;
        logic [2:0][33:0]      wv;
        logic [2:0][37:0]      wd;
    } twist_t;

    // Arctangent table, truncated Q2.30
    function automatic logic signed [33:0] atan_q30(input int idx);
        logic signed [33:0] r;
        begin
            case (idx)
                0:  r = 34'sh03243F6A8;
                1:  r = 34'sh01DAC6705;
                2:  r = 34'sh00FADBAFC;
                3:  r = 34'sh007F56EA6;
                4:  r = 34'sh003FEAB76;
                5:  r = 34'sh001FFD55B;
                6:  r = 34'sh000FFFAAA;
                7:  r = 34'sh0007FFF55;
                8:  r = 34'sh0003FFFEA;
                9:  r = 34'sh0001FFFFD;
                10: r = 34'sh0000FFFFF;
                11: r = 34'sh00007FFFF;
                12: r = 34'sh00003FFFF;
                13: r = 34'sh00001FFFF;
                14: r = 34'sh00000FFFF;
                15: r = 34'sh000007FFF;
                16: r = 34'sh000003FFF;
                17: r = 34'sh000001FFF;
                18: r = 34'sh000000FFF;
                19: r = 34'sh0000007FF;
                20: r = 34'sh0000003FF;
                21: r = 34'sh0000001FF;
                22: r = 34'sh0000000FF;
                23: r = 34'sh00000007F;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

    // Saturate a wide signed value to 16 bits
    function automatic logic signed [15:0] sat16(input logic signed [57:0] v);
        logic signed [15:0] r;
        begin
            if (v > 58'sd32767)
                r = 16'sh7FFF;
            else if (v < -58'sd32768)
                r = 16'sh8000;
            else
                r = v[15:0];
            return r;
        end
    endfunction

endpackage

FILE: hdl/tes3_cordic_stage.sv
// ----------------------------------------------------------------------------
// tes3_cordic_stage
// One registered rotation-mode CORDIC iteration with a fixed shift.
// ----------------------------------------------------------------------------
module tes3_cordic_stage #(
    parameter int STEP = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              i_valid,
    input  tes3_pkg::cordic_t i_data,
    output logic              o_valid,
    output tes3_pkg::cordic_t o_data
);

    logic signed [33:0] x_in;
    logic signed [33:0] y_in;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [33:0] ang;
    tes3_pkg::cordic_t  data_next;
    tes3_pkg::cordic_t  data_reg;
    logic               valid_reg;

    // Rotate toward zero residual angle
    always_comb
    begin
        x_in = i_data.x;
        y_in = i_data.y;
        dx   = y_in >>> STEP;
        dy   = x_in >>> STEP;
        ang  = tes3_pkg::atan_q30(STEP);
        data_next = i_data;
        if (i_data.z >= 0)
        begin
            data_next.x = x_in - dx;
            data_next.y = y_in + dy;
            data_next.z = i_data.z - ang;
        end
        else
        begin
            data_next.x = x_in + dx;
            data_next.y = y_in - dy;
            data_next.z = i_data.z + ang;
        end
    end

    // Advance the valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= i_valid;
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign o_valid = valid_reg;
    assign o_data  = data_reg;

endmodule

FILE: hdl/tes3_derive.sv
// ----------------------------------------------------------------------------
// tes3_derive
// Two register stages that form W^2, W v and w(w.v) from the twist.
// ----------------------------------------------------------------------------
module tes3_derive (
    input  logic               clk,
    input  logic signed [15:0] axis_x,
    input  logic signed [15:0] axis_y,
    input  logic signed [15:0] axis_z,
    input  logic signed [15:0] linear_x,
    input  logic signed [15:0] linear_y,
    input  logic signed [15:0] linear_z,
    output tes3_pkg::twist_t   twist
);

    logic signed [15:0] w [3];
    logic signed [15:0] v [3];

    logic signed [33:0] sq_next  [3];
    logic signed [33:0] sq_reg   [3];
    logic signed [33:0] cr_next  [3];   // w0w1, w0w2, w1w2
    logic signed [33:0] cr_reg   [3];
    logic signed [33:0] wv_next  [3];
    logic signed [33:0] wv_reg   [3];
    logic signed [33:0] dot_next;
    logic signed [33:0] dot_reg;
    logic [2:0][15:0]   w_reg;
    logic [2:0][15:0]   v_reg;
    logic               zero_reg;
    tes3_pkg::twist_t   twist_next;
    tes3_pkg::twist_t   twist_reg;
    logic signed [49:0] wdp;

    assign w[0] = axis_x;
    assign w[1] = axis_y;
    assign w[2] = axis_z;
    assign v[0] = linear_x;
    assign v[1] = linear_y;
    assign v[2] = linear_z;

    // First stage: products of the register values
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            sq_next[i] = 34'(w[i]) * 34'(w[i]);
        cr_next[0] = 34'(w[0]) * 34'(w[1]);
        cr_next[1] = 34'(w[0]) * 34'(w[2]);
        cr_next[2] = 34'(w[1]) * 34'(w[2]);
        wv_next[0] = 34'(w[1]) * 34'(v[2]) - 34'(w[2]) * 34'(v[1]);
        wv_next[1] = 34'(w[2]) * 34'(v[0]) - 34'(w[0]) * 34'(v[2]);
        wv_next[2] = 34'(w[0]) * 34'(v[1]) - 34'(w[1]) * 34'(v[0]);
        dot_next   = 34'(w[0]) * 34'(v[0]) + 34'(w[1]) * 34'(v[1])
                   + 34'(w[2]) * 34'(v[2]);
    end

    always_ff @(posedge clk)
    begin
        sq_reg   <= sq_next;
        cr_reg   <= cr_next;
        wv_reg   <= wv_next;
        dot_reg  <= dot_next;
        zero_reg <= (axis_x == '0) && (axis_y == '0) && (axis_z == '0);
        for (int i = 0; i < 3; i++)
        begin
            w_reg[i] <= w[i];
            v_reg[i] <= v[i];
        end
    end

    // Second stage: W^2 = w w' - |w|^2 I, and w(w.v) rounded to Q.29
    always_comb
    begin
        wdp = '0;
        twist_next.zero = zero_reg;
        twist_next.w    = w_reg;
        twist_next.v    = v_reg;
        twist_next.w2[0][0] = -(sq_reg[1] + sq_reg[2]);
        twist_next.w2[1][1] = -(sq_reg[0] + sq_reg[2]);
        twist_next.w2[2][2] = -(sq_reg[0] + sq_reg[1]);
        twist_next.w2[0][1] = cr_reg[0];
        twist_next.w2[1][0] = cr_reg[0];
        twist_next.w2[0][2] = cr_reg[1];
        twist_next.w2[2][0] = cr_reg[1];
        twist_next.w2[1][2] = cr_reg[2];
        twist_next.w2[2][1] = cr_reg[2];
        for (int i = 0; i < 3; i++)
        begin
            twist_next.wv[i] = wv_reg[i];
            wdp = 50'($signed(w_reg[i])) * 50'(dot_reg) + 50'sd4096;
            twist_next.wd[i] = 38'(wdp >>> 13);
        end
    end

    always_ff @(posedge clk)
    begin
        twist_reg <= twist_next;
    end

    assign twist = twist_reg;

endmodule

FILE: hdl/tes3_rodrigues.sv
// ----------------------------------------------------------------------------
// tes3_rodrigues
// Four register stages that build R and t from sine, cosine and the twist.
// ----------------------------------------------------------------------------
module tes3_rodrigues (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               i_valid,
    input  logic signed [15:0] sin_q14,
    input  logic signed [15:0] cos_q14,
    input  logic signed [15:0] th,
    input  tes3_pkg::twist_t   twist,
    output logic               o_valid,
    output logic [8:0][15:0]   rot,
    output logic [2:0][15:0]   trans
);

    localparam logic signed [16:0] UNIT_Q14_EXT = 17'(tes3_pkg::UNIT_Q14);

    logic signed [16:0] wm   [3][3];
    logic signed [16:0] omc;

    // stage 1
    logic signed [33:0] ps_next [3][3];
    logic signed [33:0] ps_reg  [3][3];
    logic signed [50:0] po_next [3][3];
    logic signed [50:0] po_reg  [3][3];
    logic signed [31:0] vth_next [3];
    logic signed [31:0] vth1_reg [3];
    logic signed [15:0] th1_reg;
    logic               v1_reg;

    // stage 2
    logic signed [57:0] racc;
    logic signed [15:0] r_next  [3][3];
    logic signed [15:0] r2_reg  [3][3];
    logic signed [53:0] tw_next [3];
    logic signed [53:0] tw2_reg [3];
    logic signed [31:0] vth2_reg [3];
    logic               v2_reg;

    // stage 3
    logic signed [16:0] im;
    logic signed [50:0] mp_next [3][3];
    logic signed [50:0] mp_reg  [3][3];
    logic signed [15:0] r3_reg  [3][3];
    logic signed [53:0] tw3_reg [3];
    logic signed [31:0] vth3_reg [3];
    logic               v3_reg;

    // stage 4
    logic signed [57:0] tacc;
    logic signed [57:0] pacc;
    logic [8:0][15:0]   rot_next;
    logic [8:0][15:0]   rot_reg;
    logic [2:0][15:0]   trans_next;
    logic [2:0][15:0]   trans_reg;
    logic               v4_reg;

    // Skew matrix of the axis
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            wm[i][i] = '0;
        wm[0][1] = -17'($signed(twist.w[2]));
        wm[0][2] =  17'($signed(twist.w[1]));
        wm[1][0] =  17'($signed(twist.w[2]));
        wm[1][2] = -17'($signed(twist.w[0]));
        wm[2][0] = -17'($signed(twist.w[1]));
        wm[2][1] =  17'($signed(twist.w[0]));
        omc = 17'(UNIT_Q14_EXT) - 17'(cos_q14);
    end

    // Stage 1: s*W and (1-c)*W^2
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                ps_next[i][j] = 34'(sin_q14) * 34'(wm[i][j]);
                po_next[i][j] = 51'(omc) * 51'($signed(twist.w2[i][j]));
            end
            vth_next[i] = 32'($signed(twist.v[i])) * 32'(th);
        end
    end

    // Stage 2: round R, and w(w.v)*theta
    always_comb
    begin
        racc = '0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                racc = 58'(po_reg[i][j]) + (58'(ps_reg[i][j]) <<< 14)
                     + 58'sd134217728;
                if (i == j)
                    racc = racc + (58'sd1 <<< 42);
                r_next[i][j] = tes3_pkg::sat16(racc >>> 28);
            end
            tw_next[i] = 54'($signed(twist.wd[i])) * 54'(th1_reg);
        end
    end

    // Stage 3: (I-R) times W v
    always_comb
    begin
        im = '0;
        for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++)
            begin
                im = ((i == k) ? UNIT_Q14_EXT : 17'sd0) - 17'(r2_reg[i][k]);
                mp_next[i][k] = 51'(im) * 51'($signed(twist.wv[k]));
            end
    end

    // Stage 4: sum, round and select the prismatic case
    always_comb
    begin
        tacc = '0;
        pacc = '0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
                rot_next[i * 3 + j] = twist.zero
                    ? ((i == j) ? tes3_pkg::UNIT_Q14 : 16'sd0) : r3_reg[i][j];
            tacc = 58'(mp_reg[i][0]) + 58'(mp_reg[i][1]) + 58'(mp_reg[i][2])
                 + 58'(tw3_reg[i]) + 58'sd134217728;
            pacc = 58'(vth3_reg[i]) + 58'sd4096;
            trans_next[i] = twist.zero ? tes3_pkg::sat16(pacc >>> 13)
                                       : tes3_pkg::sat16(tacc >>> 28);
        end
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= i_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ps_reg    <= ps_next;
            po_reg    <= po_next;
            vth1_reg  <= vth_next;
            th1_reg   <= th;
            r2_reg    <= r_next;
            tw2_reg   <= tw_next;
            vth2_reg  <= vth1_reg;
            mp_reg    <= mp_next;
            r3_reg    <= r2_reg;
            tw3_reg   <= tw2_reg;
            vth3_reg  <= vth2_reg;
            rot_reg   <= rot_next;
            trans_reg <= trans_next;
        end
    end

    assign o_valid = v4_reg;
    assign rot     = rot_reg;
    assign trans   = trans_reg;

endmodule

FILE: hdl/twist_exponential_se3.sv
// Throughput: one item per cycle while no result is held; the unrolled CORDIC, one register stage per
// iteration, and the four matrix stages all advance together.
// A stalled result holds the whole pipeline; nothing is dropped.
// Reset clears all valid bits and loads the twist registers (axis along z).
// ----------------------------------------------------------------------------
// twist_exponential_se3
// Top level: twist registers, angle reduction, CORDIC pipeline, Rodrigues.
// ----------------------------------------------------------------------------
module twist_exponential_se3 #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] joint_angle,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] rot_00,
    output logic signed [15:0] rot_01,
    output logic signed [15:0] rot_02,
    output logic signed [15:0] rot_10,
    output logic signed [15:0] rot_11,
    output logic signed [15:0] rot_12,
    output logic signed [15:0] rot_20,
    output logic signed [15:0] rot_21,
    output logic signed [15:0] rot_22,
    output logic signed [15:0] trans_x,
    output logic signed [15:0] trans_y,
    output logic signed [15:0] trans_z
);

    logic signed [15:0] axis_x_reg;
    logic signed [15:0] axis_y_reg;
    logic signed [15:0] axis_z_reg;
    logic signed [15:0] linear_x_reg;
    logic signed [15:0] linear_y_reg;
    logic signed [15:0] linear_z_reg;

    logic               en;
    logic signed [17:0] th_ext;
    logic signed [17:0] th_wrap;
    logic signed [17:0] th_fold;
    logic               flip;
    logic               red_valid_reg;
    tes3_pkg::cordic_t  red_next;
    tes3_pkg::cordic_t  red_reg;

    logic               cv   [CORDIC_STEPS + 1];
    tes3_pkg::cordic_t  cd   [CORDIC_STEPS + 1];

    logic signed [33:0] ys;
    logic signed [33:0] xs;
    logic signed [15:0] sin_next;
    logic signed [15:0] cos_next;
    logic signed [15:0] sin_reg;
    logic signed [15:0] cos_reg;
    logic signed [15:0] th_reg;
    logic               sc_valid_reg;

    tes3_pkg::twist_t   twist;
    logic               rod_valid;
    logic [8:0][15:0]   rot;
    logic [2:0][15:0]   trans;

    // Move the pipeline unless a finished result is held
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    // Twist registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_x_reg   <= '0;
            axis_y_reg   <= '0;
            axis_z_reg   <= tes3_pkg::UNIT_Q14;
            linear_x_reg <= '0;
            linear_y_reg <= '0;
            linear_z_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tes3_pkg::REG_AXIS_X:   axis_x_reg   <= cfg_data;
                tes3_pkg::REG_AXIS_Y:   axis_y_reg   <= cfg_data;
                tes3_pkg::REG_AXIS_Z:   axis_z_reg   <= cfg_data;
                tes3_pkg::REG_LINEAR_X: linear_x_reg <= cfg_data;
                tes3_pkg::REG_LINEAR_Y: linear_y_reg <= cfg_data;
                tes3_pkg::REG_LINEAR_Z: linear_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Reduce the angle to [-pi/2, pi/2] and note a cosine flip
    always_comb
    begin
        th_ext = 18'(joint_angle);
        if (th_ext > tes3_pkg::ANG_PI)
            th_wrap = th_ext - tes3_pkg::ANG_TWO_PI;
        else if (th_ext < -tes3_pkg::ANG_PI)
            th_wrap = th_ext + tes3_pkg::ANG_TWO_PI;
        else
            th_wrap = th_ext;
        flip = 1'b0;
        if (th_wrap > tes3_pkg::ANG_HALF_PI)
        begin
            th_fold = tes3_pkg::ANG_PI - th_wrap;
            flip    = 1'b1;
        end
        else if (th_wrap < -tes3_pkg::ANG_HALF_PI)
        begin
            th_fold = -tes3_pkg::ANG_PI - th_wrap;
            flip    = 1'b1;
        end
        else
            th_fold = th_wrap;
        red_next.flip = flip;
        red_next.th   = joint_angle;
        red_next.x    = tes3_pkg::CORDIC_GAIN;
        red_next.y    = '0;
        red_next.z    = {th_fold[16:0], 17'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            red_valid_reg <= 1'b0;
        else if (en)
            red_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            red_reg <= red_next;
    end

    assign cv[0] = red_valid_reg;
    assign cd[0] = red_reg;

    // CORDIC, one registered iteration per step
    for (genvar g = 0; g < CORDIC_STEPS; g++)
    begin : g_cordic
        tes3_cordic_stage #(
            .STEP (g)
        ) u_stage (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .i_valid (cv[g]),
            .i_data  (cd[g]),
            .o_valid (cv[g + 1]),
            .o_data  (cd[g + 1])
        );
    end

    // Round sine and cosine to Q2.14, clamp, apply the fold
    always_comb
    begin
        ys = (cd[CORDIC_STEPS].y + 34'sd32768) >>> 16;
        xs = (cd[CORDIC_STEPS].x + 34'sd32768) >>> 16;
        if (ys > 34'sd16384)
            sin_next = tes3_pkg::UNIT_Q14;
        else if (ys < -34'sd16384)
            sin_next = -tes3_pkg::UNIT_Q14;
        else
            sin_next = ys[15:0];
        if (xs > 34'sd16384)
            cos_next = tes3_pkg::UNIT_Q14;
        else if (xs < -34'sd16384)
            cos_next = -tes3_pkg::UNIT_Q14;
        else
            cos_next = xs[15:0];
        if (cd[CORDIC_STEPS].flip)
            cos_next = -cos_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sc_valid_reg <= 1'b0;
        else if (en)
            sc_valid_reg <= cv[CORDIC_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_reg <= sin_next;
            cos_reg <= cos_next;
            th_reg  <= cd[CORDIC_STEPS].th;
        end
    end

    tes3_derive u_derive (
        .clk      (clk),
        .axis_x   (axis_x_reg),
        .axis_y   (axis_y_reg),
        .axis_z   (axis_z_reg),
        .linear_x (linear_x_reg),
        .linear_y (linear_y_reg),
        .linear_z (linear_z_reg),
        .twist    (twist)
    );

    tes3_rodrigues u_rodrigues (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .i_valid (sc_valid_reg),
        .sin_q14 (sin_reg),
        .cos_q14 (cos_reg),
        .th      (th_reg),
        .twist   (twist),
        .o_valid (rod_valid),
        .rot     (rot),
        .trans   (trans)
    );

    assign out_valid = rod_valid;
    assign rot_00    = rot[0];
    assign rot_01    = rot[1];
    assign rot_02    = rot[2];
    assign rot_10    = rot[3];
    assign rot_11    = rot[4];
    assign rot_12    = rot[5];
    assign rot_20    = rot[6];
    assign rot_21    = rot[7];
    assign rot_22    = rot[8];
    assign trans_x   = trans[0];
    assign trans_y   = trans[1];
    assign trans_z   = trans[2];

`ifndef SYNTHESIS
    // A zero axis gives the identity rotation
    a_zero_axis_identity: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (axis_x_reg == '0) && (axis_y_reg == '0) && (axis_z_reg == '0)
        |-> (rot_00 == 16'sd16384) && (rot_01 == 16'sd0) && (rot_11 == 16'sd16384))
        else $error("zero axis did not give identity rotation");

    // A held result freezes the first pipeline stage and the sine/cosine stage
    a_stall_holds_entry: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> $stable(red_valid_reg) && $stable(sc_valid_reg))
        else $error("pipeline advanced while the result was held");
`endif

endmodule

FILE: test/twist_exponential_se3_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// twist_exponential_se3_test
// Drives joint angles through the twist exponential under several screw axes
// and linear parts, predicts each transform in fixed point and checks every
// rotation and translation field of each result in order.
// ----------------------------------------------------------------------------
module twist_exponential_se3_test;

    localparam int STEPS       = 16;
    localparam int LATENCY     = STEPS + 6;
    localparam int WATCH_LIMIT = 20000;

    typedef struct {
        logic signed [15:0] rot [9];
        logic signed [15:0] trans [3];
    } transform_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic signed [15:0] joint_angle;
    logic               out_valid;
    logic               out_stall;
    logic signed [15:0] rot [9];
    logic signed [15:0] trans [3];

    // twist held by the predictor
    logic signed [15:0] axis [3];
    logic signed [15:0] lin [3];

    logic signed [15:0] angle_queue [$];
    transform_t         transform_queue [$];
    int                 failures;
    int                 watch_count;
    bit                 hold_receiver;
    int                 send_gap;
    int                 recv_gap;
    string              trans_names [3] = '{"trans_x", "trans_y", "trans_z"};

    twist_exponential_se3 #(.CORDIC_STEPS(STEPS)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .joint_angle(joint_angle),
        .out_valid(out_valid), .out_stall(out_stall),
        .rot_00(rot[0]), .rot_01(rot[1]), .rot_02(rot[2]),
        .rot_10(rot[3]), .rot_11(rot[4]), .rot_12(rot[5]),
        .rot_20(rot[6]), .rot_21(rot[7]), .rot_22(rot[8]),
        .trans_x(trans[0]), .trans_y(trans[1]), .trans_z(trans[2])
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    // Fixed-length CORDIC sine and cosine in Q2.14 after quadrant folding
    function automatic void angle_sincos(longint th, output longint s, output longint c);
        longint x, y, z, dx, dy;
        bit     flip;
        longint atan_tab [24] = '{
            64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
            64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
            64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
            64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
            64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
        flip = 0;
        x = 64'h26DD3B6A;
        y = 0;
        if (th > 25736)
            th = th - 51472;
        else if (th < -25736)
            th = th + 51472;
        if (th > 12868)
        begin
            th = 25736 - th;
            flip = 1;
        end
        else if (th < -12868)
        begin
            th = -25736 - th;
            flip = 1;
        end
        z = th * 131072;
        for (int i = 0; i < STEPS && i < 24; i++)
        begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= atan_tab[i];
            end
            else
            begin
                x += dx;
                y -= dy;
                z += atan_tab[i];
            end
        end
        s = clip(round_shift(y, 16), -16384, 16384);
        c = clip(round_shift(x, 16), -16384, 16384);
        if (flip)
            c = -c;
    endfunction

    // Expected transform for one joint angle under the current twist
    function automatic transform_t screw_transform(logic signed [15:0] angle);
        transform_t r;
        longint     w [3], v [3], sk [3][3], sk2 [3][3], rm [3][3], wv [3];
        longint     th, s, c, omc, dot, acc;
        th = angle;
        dot = 0;
        for (int i = 0; i < 3; i++)
        begin
            w[i] = axis[i];
            v[i] = lin[i];
        end
        if (w[0] == 0 && w[1] == 0 && w[2] == 0)
        begin
            // prismatic joint: identity rotation, pure slide
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                    r.rot[i*3+j] = (i == j) ? 16'sd16384 : 16'sd0;
                r.trans[i] = 16'(clip(round_shift(v[i] * th, 13), -32768, 32767));
            end
            return r;
        end
        angle_sincos(th, s, c);
        omc = 16384 - c;
        sk = '{'{0, -w[2], w[1]}, '{w[2], 0, -w[0]}, '{-w[1], w[0], 0}};
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                acc = 0;
                for (int k = 0; k < 3; k++)
                    acc += sk[i][k] * sk[k][j];
                sk2[i][j] = acc;
            end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                acc = (i == j) ? (longint'(1) <<< 42) : 0;
                acc += s * sk[i][j] * 16384;
                acc += omc * sk2[i][j];
                rm[i][j] = clip(round_shift(acc, 28), -32768, 32767);
                r.rot[i*3+j] = 16'(rm[i][j]);
            end
        for (int i = 0; i < 3; i++)
        begin
            acc = 0;
            for (int k = 0; k < 3; k++)
                acc += sk[i][k] * v[k];
            wv[i] = acc;
            dot += w[i] * v[i];
        end
        for (int i = 0; i < 3; i++)
        begin
            acc = 0;
            for (int k = 0; k < 3; k++)
                acc += (((i == k) ? 16384 : 0) - rm[i][k]) * wv[k];
            acc += round_shift(w[i] * dot, 13) * th;
            r.trans[i] = 16'(clip(round_shift(acc, 28), -32768, 32767));
        end
        return r;
    endfunction

    // Drive: offer the next pending angle after a random gap
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            joint_angle <= '0;
            send_gap    <= 0;
        end
        else if (!(in_valid && in_stall))
        begin
            if (in_valid)
                transform_queue.push_back(screw_transform(joint_angle));
            if (send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (angle_queue.size() > 0)
            begin
                in_valid    <= 1'b1;
                joint_angle <= angle_queue.pop_front();
                send_gap    <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receive: check each accepted result and draw the next stall
    always @(posedge clk or negedge rst_n)
    begin
        transform_t exp_t;
        int         gap;
        if (!rst_n)
        begin
            out_stall   <= 1'b0;
            recv_gap    <= 0;
            watch_count <= 0;
        end
        else
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                watch_count <= 0;
            else
                watch_count <= watch_count + 1;
            if (out_valid && !out_stall)
            begin
                if (transform_queue.size() == 0)
                begin
                    $error("result with no expected transform");
                    failures++;
                end
                else
                begin
                    exp_t = transform_queue.pop_front();
                    for (int i = 0; i < 9; i++)
                        if (rot[i] !== exp_t.rot[i])
                        begin
                            $error("rot_%0d%0d expected %0d actual %0d", i / 3, i % 3,
                                   exp_t.rot[i], rot[i]);
                            failures++;
                        end
                    for (int i = 0; i < 3; i++)
                        if (trans[i] !== exp_t.trans[i])
                        begin
                            $error("%s expected %0d actual %0d", trans_names[i],
                                   exp_t.trans[i], trans[i]);
                            failures++;
                        end
                end
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
                recv_gap  <= gap;
                out_stall <= hold_receiver || (gap > 0);
            end
            else if (recv_gap > 0)
            begin
                recv_gap  <= recv_gap - 1;
                out_stall <= hold_receiver || (recv_gap > 1);
            end
            else
                out_stall <= hold_receiver;
        end
    end

    // Watchdog on cycles without any accepted item
    always @(posedge clk)
    begin
        if (watch_count >= WATCH_LIMIT)
        begin
            $display("twist_exponential_se3_test failed");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] index, logic signed [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        if (index <= tes3_pkg::REG_LINEAR_Z)
        begin
            if (index < tes3_pkg::REG_LINEAR_X)
                axis[index] = value;
            else
                lin[index - tes3_pkg::REG_LINEAR_X] = value;
        end
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_twist(logic signed [15:0] ax, ay, az, lx, ly, lz);
        write_reg(tes3_pkg::REG_AXIS_X, ax);
        write_reg(tes3_pkg::REG_AXIS_Y, ay);
        write_reg(tes3_pkg::REG_AXIS_Z, az);
        write_reg(tes3_pkg::REG_LINEAR_X, lx);
        write_reg(tes3_pkg::REG_LINEAR_Y, ly);
        write_reg(tes3_pkg::REG_LINEAR_Z, lz);
    endtask

    // Let the pipeline run dry before touching the twist
    task automatic drain();
        while (angle_queue.size() > 0 || in_valid || transform_queue.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    function automatic logic signed [15:0] random_angle();
        case ($urandom_range(0, 4))
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 200)) - 16'sd100;
            2: return 16'sd25736 + 16'($urandom_range(0, 8)) - 16'sd4;
            3: return 16'sd12868 * 16'($urandom_range(0, 4)) - 16'sd25736
                      + 16'($urandom_range(0, 4)) - 16'sd2;
            default: return 16'($urandom_range(0, 51472)) - 16'sd25736;
        endcase
    endfunction

    task automatic random_twist();
        logic signed [15:0] a [3];
        case ($urandom_range(0, 3))
            0: a = '{16'sd0, 16'sd0, 16'sd16384};
            1: a = '{16'sd11585, -16'sd11585, 16'sd0};
            2: a = '{16'sd9459, 16'sd9459, -16'sd9459};
            default: a = '{16'($urandom_range(0, 32768)) - 16'sd16384,
                           16'($urandom_range(0, 32768)) - 16'sd16384,
                           16'($urandom_range(0, 32768)) - 16'sd16384};
        endcase
        set_twist(a[0], a[1], a[2], 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    initial
    begin
        logic signed [15:0] corner [] = '{16'sh8000, 16'sh7FFF, 16'sd0, 16'sd1, -16'sd1,
            16'sd25736, 16'sd25737, -16'sd25736, -16'sd25737, 16'sd12868, 16'sd12869,
            -16'sd12868, -16'sd12869, 16'sd51472, 16'sh5555, 16'shAAAA};
        failures      = 0;
        hold_receiver = 0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        axis = '{16'sd0, 16'sd0, 16'sd16384};
        lin  = '{16'sd0, 16'sd0, 16'sd0};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset twist, then extremes: prismatic slide and full-scale axes
        foreach (corner[i]) angle_queue.push_back(corner[i]);
        drain();
        set_twist(16'sd0, 16'sd0, 16'sd0, 16'sh7FFF, 16'sh8000, 16'sd4096);
        foreach (corner[i]) angle_queue.push_back(corner[i]);
        drain();
        set_twist(-16'sd16384, 16'sd16384, 16'sd16384, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
        write_reg(3'd7, 16'shFFFF);
        foreach (corner[i]) angle_queue.push_back(corner[i]);
        drain();

        // random phases under changing twists
        for (int phase = 0; phase < 14; phase++)
        begin
            random_twist();
            for (int n = 0; n < 100; n++)
                angle_queue.push_back(random_angle());
            if (phase == 4)
            begin
                // long receiver hold while items keep arriving
                hold_receiver = 1;
                repeat (200) @(posedge clk);
                hold_receiver = 0;
            end
            if (phase == 8)
            begin
                // sender pauses until everything is back
                while (angle_queue.size() > 50) @(posedge clk);
                angle_queue.delete();
                while (in_valid || transform_queue.size() > 0) @(posedge clk);
                for (int n = 0; n < 50; n++)
                    angle_queue.push_back(random_angle());
            end
            drain();
        end

        if (failures == 0)
            $display("twist_exponential_se3_test passed");
        else
            $display("twist_exponential_se3_test failed");
        $finish;
    end

endmodule

FILE: sim.f
hdl/tes3_pkg.sv
hdl/tes3_cordic_stage.sv
hdl/tes3_derive.sv
hdl/tes3_rodrigues.sv
hdl/twist_exponential_se3.sv
test/twist_exponential_se3_test.sv
